>>> rtl/nsp_pkg.sv
// Shared types, character codes and field tables of the sentence parser.
package nsp_pkg;

    localparam int MAX_QUANTITIES_DEF = 12;
    localparam int FRAC_DIGITS_DEF    = 5;
    localparam int VALUE_BITS_DEF     = 41;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TIME,
        OP_STATUS,
        OP_NUM,
        OP_INT,
        OP_GEO,
        OP_NEGS,
        OP_NEGW,
        OP_QUAL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] id;
    } t_rule;

    localparam logic [1:0] KIND_RMC  = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_VTG  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_NAME   = 2'd1;
    localparam logic [1:0] VERDICT_FIELDS = 2'd2;

    localparam logic [39:0] NAME_RMC = 40'h4750524D43;
    localparam logic [39:0] NAME_GGA = 40'h4750474741;
    localparam logic [39:0] NAME_VTG = 40'h4750565447;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [4:0] MAX_COMMAS_RMC = 5'd12;
    localparam logic [4:0] MAX_COMMAS_OTH = 5'd15;

    function automatic logic [31:0] pow10(input logic [2:0] e);
        logic [31:0] p;
        case (e)
            3'd0: p = 32'd1;
            3'd1: p = 32'd10;
            3'd2: p = 32'd100;
            3'd3: p = 32'd1000;
            3'd4: p = 32'd10000;
            3'd5: p = 32'd100000;
            3'd6: p = 32'd1000000;
            default: p = 32'd10000000;
        endcase
        return p;
    endfunction

    // Decode rule of the field that follows comma number "comma".
    function automatic t_rule rule_of(input logic [1:0] kind, input logic [4:0] comma);
        t_rule      r;
        logic [4:0] fi;
        r  = '{OP_NONE, 4'd0};
        fi = comma - 5'd1;
        if (comma != 5'd0 && !fi[4]) begin
            case (kind)
                KIND_RMC: begin
                    case (fi[3:0])
                        4'd0:    r = '{OP_TIME,   4'd0};
                        4'd1:    r = '{OP_STATUS, 4'd3};
                        4'd2:    r = '{OP_NUM,    4'd4};
                        4'd4:    r = '{OP_NUM,    4'd5};
                        4'd6:    r = '{OP_NUM,    4'd6};
                        4'd7:    r = '{OP_NUM,    4'd7};
                        4'd8:    r = '{OP_TIME,   4'd8};
                        4'd9:    r = '{OP_NUM,    4'd11};
                        4'd10:   r = '{OP_NEGW,   4'd11};
                        default: r = '{OP_NONE,   4'd0};
                    endcase
                end
                KIND_GGA: begin
                    case (fi[3:0])
                        4'd0:    r = '{OP_TIME, 4'd0};
                        4'd1:    r = '{OP_GEO,  4'd3};
                        4'd2:    r = '{OP_NEGS, 4'd3};
                        4'd3:    r = '{OP_GEO,  4'd4};
                        4'd4:    r = '{OP_NEGW, 4'd4};
                        4'd5:    r = '{OP_QUAL, 4'd5};
                        4'd6:    r = '{OP_INT,  4'd6};
                        4'd7:    r = '{OP_NUM,  4'd7};
                        4'd8:    r = '{OP_NUM,  4'd8};
                        4'd10:   r = '{OP_NUM,  4'd9};
                        4'd12:   r = '{OP_NUM,  4'd10};
                        4'd13:   r = '{OP_NUM,  4'd11};
                        default: r = '{OP_NONE, 4'd0};
                    endcase
                end
                KIND_VTG: begin
                    case (fi[3:0])
                        4'd0:    r = '{OP_NUM,  4'd0};
                        4'd2:    r = '{OP_NUM,  4'd1};
                        4'd4:    r = '{OP_NUM,  4'd2};
                        4'd6:    r = '{OP_NUM,  4'd3};
                        default: r = '{OP_NONE, 4'd0};
                    endcase
                end
                default: r = '{OP_NONE, 4'd0};
            endcase
        end
        return r;
    endfunction

    function automatic logic [1:0] decide_kind(input logic [39:0] name, input logic len_ok);
        logic [1:0] k;
        k = KIND_NONE;
        if (len_ok) begin
            if (name == NAME_RMC)      k = KIND_RMC;
            else if (name == NAME_GGA) k = KIND_GGA;
            else if (name == NAME_VTG) k = KIND_VTG;
        end
        return k;
    endfunction

    function automatic logic [3:0] kind_count(input logic [1:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_RMC: n = 4'd12;
            KIND_GGA: n = 4'd12;
            KIND_VTG: n = 4'd4;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] verdict_of(input logic [1:0] kind, input logic [4:0] comma);
        logic [1:0] v;
        if (kind == KIND_NONE)
            v = VERDICT_NAME;
        else if (comma > ((kind == KIND_RMC) ? MAX_COMMAS_RMC : MAX_COMMAS_OTH))
            v = VERDICT_FIELDS;
        else
            v = VERDICT_OK;
        return v;
    endfunction

endpackage

>>> rtl/nsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/nmea_sentence_parser_unit.sv
// Top level of the NMEA sentence parser: character front end, store pipeline, result emitter.
//
// Input channel (i_in_valid / o_in_ready) takes one character per beat, i_final_char on the
// last one of a sentence. The first character is skipped, the name up to the first comma
// selects RMC, GGA or VTG, and each field is decoded as it streams in.
// A new character is taken in every cycle; the only stalls are the cycle after a final
// character that is a comma closing a field, and a final character while the previous
// sentence is still in the store pipeline or being read out of the store.
// Decoded quantities pass a three-stage pipeline (degree conversion multiplies) and are
// written into a RAM that holds two banks, one per sentence, so the next sentence fills one
// bank while the other is read out.
// Output channel (o_out_valid / i_out_ready): once the final entry leaves the store pipeline
// the emitter starts; it gives its results in turn (one RAM read, then the output
// register), 12 results for RMC and GGA, 4 for VTG, one for a rejected sentence, and the
// last beat carries o_run_end. When the receiver stalls, the output register holds and no
// further read is issued. Reset clears all control state and the per-bank entry valid bits;
// no clearing pass over the RAM is needed.
module nmea_sentence_parser_unit #(
    parameter int MAX_QUANTITIES = nsp_pkg::MAX_QUANTITIES_DEF,
    parameter int FRAC_DIGITS    = nsp_pkg::FRAC_DIGITS_DEF,
    parameter int VALUE_BITS     = nsp_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_char_in,
    input  logic                         i_final_char,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_sentence_kind,
    output logic [1:0]                   o_verdict,
    output logic [3:0]                   o_quantity_id,
    output logic signed [VALUE_BITS-1:0] o_quantity_value,
    output logic                         o_run_end
);

    localparam int MW   = VALUE_BITS - 1;
    localparam int QW   = $clog2(MAX_QUANTITIES);
    localparam int AW   = QW + 1;
    localparam int NUMW = 30;
    localparam longint unsigned P        = 64'(nsp_pkg::pow10(3'(FRAC_DIGITS)));
    localparam int              FW       = $clog2(P);
    localparam longint unsigned MAXMAG_L = (64'd1 << MW) - 64'd1;
    localparam longint unsigned GEO_UNIT = 64'd100 * P;
    localparam longint unsigned DEG_S    = MAXMAG_L / GEO_UNIT;
    localparam longint unsigned REM_S    = MAXMAG_L - DEG_S * GEO_UNIT;
    localparam longint unsigned INT_S    = MAXMAG_L / P;
    localparam longint unsigned DEG_LIM  = MAXMAG_L / 64'd10000000;
    localparam longint unsigned MULT7    = 64'(nsp_pkg::pow10(3'(7 - FRAC_DIGITS)));
    localparam logic [30:0]     RECIP60  = 31'd1145324613;
    localparam logic [MW-1:0]   MAXMAG   = '1;

    typedef struct packed {
        logic [3:0]    pos;
        logic [7:0]    first;
        logic [MW-1:0] acc;
        logic [2:0]    fcnt;
        logic          dot;
        logic          minus;
        logic          stop;
        logic [MW-1:0] ipart;
        logic [MW-1:0] deg;
        logic [3:0]    t1;
        logic [3:0]    t0;
        logic [FW-1:0] frac;
        logic [6:0]    pair;
    } t_fld;

    typedef struct packed {
        logic                  wr;
        logic                  geo;
        logic                  neg;
        logic                  minus;
        logic                  dsat;
        logic                  fin;
        logic [QW-1:0]         id;
        logic                  bank;
        logic [1:0]            kind;
        logic [1:0]            verdict;
        logic [VALUE_BITS-1:0] val;
        logic [MW-1:0]         deg;
        logic [NUMW-1:0]       num;
    } t_ent;

    // Store entry that closes a field under rule r.
    function automatic t_ent mk_end(input t_fld fl, input nsp_pkg::t_rule r);
        t_ent          e;
        logic          sat;
        logic [MW-1:0] ipv;
        logic [6:0]    mm;
        e     = '0;
        e.id  = QW'(r.id);
        e.minus = fl.minus;
        sat   = (fl.acc == MAXMAG);
        ipv   = sat ? MW'(INT_S) : fl.ipart;
        mm    = 7'(fl.t1) * 7'd10 + 7'(fl.t0);
        case (r.op)
            nsp_pkg::OP_STATUS: begin
                e.wr  = 1'b1;
                e.val = VALUE_BITS'(fl.first == nsp_pkg::CH_A);
            end
            nsp_pkg::OP_QUAL: begin
                e.wr  = 1'b1;
                e.val = (fl.first >= nsp_pkg::CH_ZERO && fl.first <= nsp_pkg::CH_TWO) ?
                        VALUE_BITS'(fl.first[1:0]) : VALUE_BITS'(3);
            end
            nsp_pkg::OP_NUM: begin
                e.wr  = 1'b1;
                e.val = fl.minus ? -{1'b0, fl.acc} : {1'b0, fl.acc};
            end
            nsp_pkg::OP_INT: begin
                e.wr  = 1'b1;
                e.val = fl.minus ? -{1'b0, ipv} : {1'b0, ipv};
            end
            nsp_pkg::OP_GEO: begin
                e.wr  = 1'b1;
                e.geo = 1'b1;
                e.deg = sat ? MW'(DEG_S) : fl.deg;
                e.num = sat ? NUMW'(REM_S) : NUMW'(64'(mm) * P) + NUMW'(fl.frac);
            end
            nsp_pkg::OP_NEGS: begin
                e.wr  = (fl.first == nsp_pkg::CH_S);
                e.neg = e.wr;
            end
            nsp_pkg::OP_NEGW: begin
                e.wr  = (fl.first == nsp_pkg::CH_W);
                e.neg = e.wr;
            end
            default: e.wr = 1'b0;
        endcase
        return e;
    endfunction

    // Front end registers.
    t_fld                        r_fld, n_fld, fc;
    logic [39:0]                 r_name, n_name;
    logic [1:0]                  r_kind, n_kind;
    logic [4:0]                  r_comma, n_comma;
    logic [6:0]                  r_idx, n_idx;
    logic                        r_bank, n_bank;
    logic                        r_xtra, n_xtra;
    logic [1:0][MAX_QUANTITIES-1:0] r_vld, n_vld;
    t_ent                        r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    logic [VALUE_BITS-1:0]       r_last;

    // Emitter and output registers.
    logic                        r_em_busy, r_rd_pend;
    logic [QW-1:0]               r_em_k, r_em_last, r_rd_k;
    logic [1:0]                  r_em_kind, r_em_verdict;
    logic                        r_em_bank;
    logic                        r_out_valid, r_run_end;
    logic [1:0]                  r_out_kind, r_out_verdict;
    logic [3:0]                  r_out_id;
    logic [VALUE_BITS-1:0]       r_out_val;

    nsp_pkg::t_rule              rule_cur, rule_fin;
    logic                        accept, blocked, is_digit, is_comma, clr, out_free, rd_issue;
    logic [3:0]                  dig;
    logic [3:0]                  tw_id;
    logic [6:0]                  pairval;
    logic [MW+4:0]               wide;
    logic [MW:0]                 fadd;
    logic [31:0]                 fpow;
    logic [1:0]                  kfin;
    logic                        we;
    logic [VALUE_BITS-1:0]       wval;
    logic [MW:0]                 gmag;
    logic [60:0]                 qprod;
    logic [VALUE_BITS-1:0]       rdata;

    assign blocked    = r_em_busy | r_rd_pend | r_s1.fin | r_s2.fin | r_s3.fin;
    assign o_in_ready = !r_xtra && !(i_final_char && blocked);
    assign accept     = i_in_valid && o_in_ready;
    assign is_digit   = (i_char_in >= nsp_pkg::CH_ZERO) && (i_char_in <= nsp_pkg::CH_NINE);
    assign dig        = is_digit ? i_char_in[3:0] : 4'd0;
    assign is_comma   = (i_char_in == nsp_pkg::CH_COMMA);

    // Field state after one ordinary character of a field.
    always_comb begin
        rule_cur = nsp_pkg::rule_of(r_kind, r_comma);
        fc       = r_fld;
        tw_id    = rule_cur.id + {2'b00, r_fld.pos[2:1]};
        pairval  = r_fld.pos[0] ? (r_fld.pair + 7'(dig)) : 7'(dig) * 7'd10;
        wide     = ({5'b0, r_fld.acc} << 3) + ({5'b0, r_fld.acc} << 1)
                   + (MW+5)'(64'(dig) * P);
        fpow     = nsp_pkg::pow10(3'(FRAC_DIGITS - 1) - r_fld.fcnt);
        fadd     = {1'b0, r_fld.acc} + (MW+1)'(64'(dig) * 64'(fpow));
        if (r_fld.pos == 4'd0) begin
            fc.first = i_char_in;
        end
        if (!r_fld.pos[0]) begin
            fc.pair = pairval;
        end
        if (!r_fld.stop) begin
            if (is_digit) begin
                if (!r_fld.dot) begin
                    fc.acc   = (wide > {5'b0, MAXMAG}) ? MAXMAG : wide[MW-1:0];
                    fc.ipart = MW'(({5'b0, r_fld.ipart} << 3) + ({5'b0, r_fld.ipart} << 1)
                                   + (MW+5)'(dig));
                    fc.deg   = MW'(({5'b0, r_fld.deg} << 3) + ({5'b0, r_fld.deg} << 1)
                                   + (MW+5)'(r_fld.t1));
                    fc.t1    = r_fld.t0;
                    fc.t0    = dig;
                end else if (r_fld.fcnt < 3'(FRAC_DIGITS)) begin
                    fc.fcnt = r_fld.fcnt + 3'd1;
                    fc.acc  = (fadd > {1'b0, MAXMAG}) ? MAXMAG : fadd[MW-1:0];
                    fc.frac = r_fld.frac + FW'(64'(dig) * 64'(fpow));
                end
            end else if (i_char_in == nsp_pkg::CH_DOT && !r_fld.dot) begin
                fc.dot = 1'b1;
            end else if ((i_char_in == nsp_pkg::CH_MINUS || i_char_in == nsp_pkg::CH_PLUS)
                         && r_fld.pos == 4'd0) begin
                fc.minus = (i_char_in == nsp_pkg::CH_MINUS);
            end else begin
                fc.stop = 1'b1;
            end
        end
        if (r_fld.pos != 4'hF) begin
            fc.pos = r_fld.pos + 4'd1;
        end
    end

    // Sentence-level control and the entry handed to the store pipeline.
    always_comb begin
        n_fld    = r_fld;
        n_name   = r_name;
        n_kind   = r_kind;
        n_comma  = r_comma;
        n_idx    = r_idx;
        n_bank   = r_bank;
        n_xtra   = 1'b0;
        n_s1     = '0;
        clr      = 1'b0;
        kfin     = r_kind;
        rule_fin = nsp_pkg::rule_of(r_kind, r_comma);
        if (r_xtra) begin
            // Final comma: close the empty last field after the one closed by the comma.
            n_s1         = mk_end('0, rule_fin);
            n_s1.fin     = 1'b1;
            n_s1.kind    = r_kind;
            n_s1.verdict = nsp_pkg::verdict_of(r_kind, r_comma);
            n_s1.bank    = r_bank;
            clr          = 1'b1;
        end else if (accept) begin
            if (r_idx != 7'd127) begin
                n_idx = r_idx + 7'd1;
            end
            if (r_idx == 7'd0) begin
                if (i_final_char) begin
                    n_s1.fin     = 1'b1;
                    n_s1.kind    = nsp_pkg::KIND_NONE;
                    n_s1.verdict = nsp_pkg::VERDICT_NAME;
                    n_s1.bank    = r_bank;
                    clr          = 1'b1;
                end
            end else if (is_comma) begin
                if (r_comma == 5'd0) begin
                    kfin   = nsp_pkg::decide_kind(r_name, r_idx == 7'd6);
                    n_kind = kfin;
                end else begin
                    n_s1      = mk_end(r_fld, rule_cur);
                    n_s1.bank = r_bank;
                end
                if (r_comma != 5'd31) begin
                    n_comma = r_comma + 5'd1;
                end
                n_fld = '0;
                if (i_final_char) begin
                    if (r_comma == 5'd0) begin
                        n_s1         = mk_end('0, nsp_pkg::rule_of(kfin, n_comma));
                        n_s1.fin     = 1'b1;
                        n_s1.kind    = kfin;
                        n_s1.verdict = nsp_pkg::verdict_of(kfin, n_comma);
                        n_s1.bank    = r_bank;
                        clr          = 1'b1;
                    end else begin
                        n_xtra = 1'b1;
                    end
                end
            end else if (r_comma == 5'd0) begin
                n_name = {r_name[31:0], i_char_in};
                if (i_final_char) begin
                    kfin         = nsp_pkg::decide_kind(n_name, r_idx == 7'd5);
                    n_s1.fin     = 1'b1;
                    n_s1.kind    = kfin;
                    n_s1.verdict = nsp_pkg::verdict_of(kfin, r_comma);
                    n_s1.bank    = r_bank;
                    clr          = 1'b1;
                end
            end else begin
                n_fld = fc;
                if (rule_cur.op == nsp_pkg::OP_TIME) begin
                    n_s1.wr   = (r_fld.pos < 4'd6);
                    n_s1.id   = QW'(tw_id);
                    n_s1.val  = VALUE_BITS'(pairval);
                    n_s1.bank = r_bank;
                end else if (i_final_char) begin
                    n_s1      = mk_end(fc, rule_cur);
                    n_s1.bank = r_bank;
                end
                if (i_final_char) begin
                    n_s1.fin     = 1'b1;
                    n_s1.kind    = r_kind;
                    n_s1.verdict = nsp_pkg::verdict_of(r_kind, r_comma);
                    clr          = 1'b1;
                end
            end
        end
        if (clr) begin
            n_fld   = '0;
            n_name  = '0;
            n_kind  = nsp_pkg::KIND_NONE;
            n_comma = '0;
            n_idx   = '0;
            n_bank  = ~r_bank;
        end
    end

    // Pipeline stages: minutes scaling, then reciprocal multiply, then write.
    always_comb begin
        n_s2 = r_s1;
        if (r_s1.geo) begin
            n_s2.num  = NUMW'(64'(r_s1.num) * MULT7);
            n_s2.dsat = (r_s1.deg > MW'(DEG_LIM));
            n_s2.deg  = MW'(r_s1.deg * 24'd10000000);
        end
        qprod = 61'(r_s2.num) * 61'(RECIP60);
        n_s3  = r_s2;
        if (r_s2.geo) begin
            n_s3.num = NUMW'(qprod[60:36]);
        end
    end

    always_comb begin
        we   = r_s3.wr;
        wval = r_s3.val;
        gmag = {1'b0, r_s3.deg} + (MW+1)'(r_s3.num);
        if (r_s3.geo) begin
            if (r_s3.dsat || gmag > {1'b0, MAXMAG}) begin
                gmag = {1'b0, MAXMAG};
            end
            wval = r_s3.minus ? -gmag : gmag;
        end else if (r_s3.neg) begin
            wval = -r_last;
        end
        n_vld = r_vld;
        if (clr) begin
            n_vld[~r_bank] = '0;
        end
        if (we) begin
            n_vld[r_s3.bank][r_s3.id] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld   <= '0;
            r_name  <= '0;
            r_kind  <= nsp_pkg::KIND_NONE;
            r_comma <= '0;
            r_idx   <= '0;
            r_bank  <= 1'b0;
            r_xtra  <= 1'b0;
            r_vld   <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
        end else begin
            r_fld   <= n_fld;
            r_name  <= n_name;
            r_kind  <= n_kind;
            r_comma <= n_comma;
            r_idx   <= n_idx;
            r_bank  <= n_bank;
            r_xtra  <= n_xtra;
            r_vld   <= n_vld;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_last <= wval;
        end
    end

    nsp_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr({r_s3.bank, r_s3.id}),
        .i_wdata(wval),
        .i_re   (rd_issue),
        .i_raddr({r_em_bank, r_em_k}),
        .o_rdata(rdata)
    );

    // Emitter: one read, then one output beat.
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_issue = r_em_busy && !r_rd_pend && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_busy   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_em_k      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_s3.fin) begin
                r_em_busy    <= 1'b1;
                r_em_k       <= '0;
                r_em_kind    <= r_s3.kind;
                r_em_verdict <= r_s3.verdict;
                r_em_bank    <= r_s3.bank;
                r_em_last    <= (r_s3.verdict != nsp_pkg::VERDICT_OK) ? '0 :
                                QW'(nsp_pkg::kind_count(r_s3.kind) - 4'd1);
            end else if (rd_issue) begin
                if (r_em_k == r_em_last) begin
                    r_em_busy <= 1'b0;
                end else begin
                    r_em_k <= r_em_k + 1'b1;
                end
            end
            r_rd_pend <= rd_issue;
            if (rd_issue) begin
                r_rd_k <= r_em_k;
            end
            if (r_rd_pend) begin
                r_out_valid   <= 1'b1;
                r_out_kind    <= r_em_kind;
                r_out_verdict <= r_em_verdict;
                r_out_id      <= 4'(r_rd_k);
                r_run_end     <= (r_rd_k == r_em_last);
                r_out_val     <= (r_em_verdict != nsp_pkg::VERDICT_OK ||
                                  !r_vld[r_em_bank][r_rd_k]) ? '0 : rdata;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sentence_kind  = r_out_kind;
    assign o_verdict        = r_out_verdict;
    assign o_quantity_id    = r_out_id;
    assign o_quantity_value = r_out_val;
    assign o_run_end        = r_run_end;

endmodule
